// ===== sv/olpo_pkg.sv =====
// shared types and constants for the ordered list position ops block
// no dependencies; used by every other file of the block
package olpo_pkg;

   // default number of list entries
   localparam int CAPACITY_DEF = 64;

   // fixed payload widths
   localparam int REQ_W = 3;
   localparam int VAL_W = 32;
   localparam int POS_W = 7;
   localparam int ST_W  = 3;

   // request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_INS_FRONT = 3'd0,
      REQ_INS_END   = 3'd1,
      REQ_INS_POS   = 3'd2,
      REQ_DEL_FRONT = 3'd3,
      REQ_DEL_END   = 3'd4,
      REQ_DEL_POS   = 3'd5,
      REQ_SEARCH    = 3'd6,
      REQ_NONE      = 3'd7
   } req_code_type;

   // status codes
   typedef enum logic [ST_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_FULL     = 3'd2,
      ST_RANGE    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

endpackage

// ===== sv/olpo_store.sv =====
// element store: one write port, one read port with registered read data
// depends on olpo_pkg for the element width
module olpo_store #(
   parameter int DEPTH = olpo_pkg::CAPACITY_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [AW-1:0]                     wr_addr,
   input  logic signed [olpo_pkg::VAL_W-1:0] wr_data,
   input  logic                              rd_en,
   input  logic [AW-1:0]                     rd_addr,
   output logic signed [olpo_pkg::VAL_W-1:0] rd_data
);

   logic signed [olpo_pkg::VAL_W-1:0] mem_ff [DEPTH];
   logic signed [olpo_pkg::VAL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ordered_list_position_ops_core.sv =====
// ordered list position ops core: bounded list of signed values, one shared walk unit
// depends on olpo_pkg and olpo_store; one request at a time, req_ready only while idle
// sequence: accept, a decode state, a walk, then the result beat; a refused request skips
// the walk; insert and delete move the entries between the index and the tail, and search
// scans from the front up to the first match or to the end of the list
// a new request is taken only once the result beat has gone; sync reset empties the list
module ordered_list_position_ops_core #(
   parameter int CAPACITY = olpo_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [olpo_pkg::REQ_W-1:0]        req_type,
   input  logic signed [olpo_pkg::VAL_W-1:0] req_value,
   input  logic [olpo_pkg::POS_W-1:0]        req_position,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [olpo_pkg::ST_W-1:0]         rsp_status,
   output logic [olpo_pkg::POS_W-1:0]        rsp_found_index,
   output logic [olpo_pkg::POS_W-1:0]        rsp_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = ((CW > olpo_pkg::POS_W) ? CW : olpo_pkg::POS_W) + 1;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_UP     = 6'b000100,
      S_DOWN   = 6'b001000,
      S_SEARCH = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type                         state_ff, state_in;
   logic [olpo_pkg::REQ_W-1:0]        type_ff, type_in;
   logic signed [olpo_pkg::VAL_W-1:0] value_ff, value_in;
   logic [olpo_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [CW-1:0]                     cnt_ff, cnt_in;
   logic [CW-1:0]                     ptr_ff, ptr_in;
   logic [CW-1:0]                     lim_ff, lim_in;
   logic                              pend_ff, pend_in;
   olpo_pkg::status_type              status_ff, status_in;
   logic [CW-1:0]                     found_ff, found_in;

   // store port controls
   logic                              wr_en;
   logic [AW-1:0]                     wr_addr;
   logic signed [olpo_pkg::VAL_W-1:0] wr_data;
   logic                              rd_en;
   logic [AW-1:0]                     rd_addr;
   logic signed [olpo_pkg::VAL_W-1:0] rd_data;

   // shared address and compare unit operands
   logic [EW-1:0] cnt_ext;
   logic [EW-1:0] ptr_ext;
   logic [EW-1:0] lim_ext;
   logic [EW-1:0] posm1_ext;
   logic [EW-1:0] ptr_dn1;
   logic [EW-1:0] ptr_dn2;
   logic [EW-1:0] ptr_up1;
   logic [EW-1:0] ptr_up2;
   logic          hit;

   logic accept;

   assign accept = req_valid && req_ready;

   olpo_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cnt_ext   = EW'(cnt_ff);
   assign ptr_ext   = EW'(ptr_ff);
   assign lim_ext   = EW'(lim_ff);
   assign posm1_ext = EW'(pos_ff) - EW'(1);
   assign ptr_dn1   = ptr_ext - EW'(1);
   assign ptr_dn2   = ptr_ext - EW'(2);
   assign ptr_up1   = ptr_ext + EW'(1);
   assign ptr_up2   = ptr_ext + EW'(2);
   assign hit       = pend_ff && (rd_data == value_ff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      type_in   = type_ff;
      value_in  = value_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      ptr_in    = ptr_ff;
      lim_in    = lim_ff;
      pend_in   = pend_ff;
      status_in = status_ff;
      found_in  = found_ff;
      wr_en     = 1'b0;
      wr_addr   = ptr_ff[AW-1:0];
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = ptr_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               type_in   = req_type;
               value_in  = req_value;
               pos_in    = req_position;
               status_in = olpo_pkg::ST_OK;
               found_in  = '0;
               pend_in   = 1'b0;
               state_in  = S_CHECK;
            end
         end

         // range checks and walk setup
         S_CHECK: begin
            pend_in = 1'b0;
            case (type_ff)
               olpo_pkg::REQ_INS_FRONT, olpo_pkg::REQ_INS_END, olpo_pkg::REQ_INS_POS: begin
                  if (cnt_ff >= CW'(CAPACITY)) begin
                     status_in = olpo_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end else if ((type_ff == olpo_pkg::REQ_INS_POS) &&
                               ((pos_ff == '0) || (posm1_ext > cnt_ext))) begin
                     status_in = olpo_pkg::ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     ptr_in   = cnt_ff;
                     state_in = S_UP;
                     if (type_ff == olpo_pkg::REQ_INS_FRONT) begin
                        lim_in = '0;
                     end else if (type_ff == olpo_pkg::REQ_INS_END) begin
                        lim_in = cnt_ff;
                     end else begin
                        lim_in = CW'(posm1_ext);
                     end
                  end
               end
               olpo_pkg::REQ_DEL_FRONT, olpo_pkg::REQ_DEL_END, olpo_pkg::REQ_DEL_POS: begin
                  if (cnt_ff == '0) begin
                     status_in = olpo_pkg::ST_EMPTY;
                     state_in  = S_DONE;
                  end else if ((type_ff == olpo_pkg::REQ_DEL_POS) &&
                               ((pos_ff == '0) || (posm1_ext >= cnt_ext))) begin
                     status_in = olpo_pkg::ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_DOWN;
                     if (type_ff == olpo_pkg::REQ_DEL_FRONT) begin
                        ptr_in = '0;
                     end else if (type_ff == olpo_pkg::REQ_DEL_END) begin
                        ptr_in = cnt_ff - CW'(1);
                     end else begin
                        ptr_in = CW'(posm1_ext);
                     end
                  end
               end
               olpo_pkg::REQ_SEARCH: begin
                  ptr_in   = '0;
                  state_in = S_SEARCH;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // open a gap: move entries up one place from the tail down to the index
         S_UP: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff[AW-1:0];
               wr_data = rd_data;
               ptr_in  = CW'(ptr_dn1);
               if (ptr_dn1 > lim_ext) begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_dn2[AW-1:0];
               end else begin
                  pend_in = 1'b0;
               end
            end else if (ptr_ff == lim_ff) begin
               wr_en    = 1'b1;
               wr_addr  = ptr_ff[AW-1:0];
               wr_data  = value_ff;
               cnt_in   = cnt_ff + CW'(1);
               state_in = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_dn1[AW-1:0];
               pend_in = 1'b1;
            end
         end

         // close the gap: move entries down one place from the index to the tail
         S_DOWN: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff[AW-1:0];
               wr_data = rd_data;
               ptr_in  = CW'(ptr_up1);
               if (ptr_up2 < cnt_ext) begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_up2[AW-1:0];
               end else begin
                  pend_in = 1'b0;
               end
            end else if (ptr_up1 >= cnt_ext) begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_up1[AW-1:0];
               pend_in = 1'b1;
            end
         end

         // linear scan, compare one entry per cycle against the key
         S_SEARCH: begin
            if (hit) begin
               found_in = ptr_ff;
               pend_in  = 1'b0;
               state_in = S_DONE;
            end else if (ptr_ext < cnt_ext) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[AW-1:0];
               ptr_in  = CW'(ptr_up1);
               pend_in = 1'b1;
            end else begin
               status_in = olpo_pkg::ST_NOTFOUND;
               pend_in   = 1'b0;
               state_in  = S_DONE;
            end
         end

         // result beat held until taken
         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      value_ff  <= value_in;
      pos_ff    <= pos_in;
      ptr_ff    <= ptr_in;
      lim_ff    <= lim_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   // ports
   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = (state_ff == S_DONE);
   assign rsp_status      = status_ff;
   assign rsp_found_index = olpo_pkg::POS_W'(found_ff);
   assign rsp_count       = olpo_pkg::POS_W'(cnt_ff);

endmodule

// ===== sv/olpo_checker.sv =====
// port level checks for the ordered list position ops block, bound to the top
// depends on olpo_pkg and ordered_list_position_ops_core
module olpo_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [olpo_pkg::ST_W-1:0]         rsp_status,
   input logic [olpo_pkg::POS_W-1:0]        rsp_found_index,
   input logic [olpo_pkg::POS_W-1:0]        rsp_count
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_found_index) && $stable(rsp_count))
      else $error("stalled result beat changed");

   // one request in flight: no new beat taken while a result waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while result pending");

   // after a request beat the block is busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready again straight after accept");

   // a found position only comes with a good status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_found_index != '0) |-> rsp_status == olpo_pkg::ST_OK)
      else $error("found position with failing status");

   // failing status never reports a position
   a_fail_no_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != olpo_pkg::ST_OK) |-> rsp_found_index == '0)
      else $error("failing status with a position");

endmodule

bind ordered_list_position_ops_core olpo_checker u_olpo_checker (.*);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for ordered_list_position_ops_core: directed corner
// cases, list sweeps between empty and full, and a long result-side stall
// depends on olpo_pkg and the core module, which in turn needs olpo_store
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_CAP    = olpo_pkg::CAPACITY_DEF;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 100;

   // one expected answer per accepted request
   typedef struct packed {
      olpo_pkg::status_type          status;
      logic [olpo_pkg::POS_W-1:0]    found;
      logic [olpo_pkg::POS_W-1:0]    count;
   } list_reply_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [olpo_pkg::REQ_W-1:0]         req_type;
   logic signed [olpo_pkg::VAL_W-1:0]  req_value;
   logic [olpo_pkg::POS_W-1:0]         req_position;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [olpo_pkg::ST_W-1:0]          rsp_status;
   logic [olpo_pkg::POS_W-1:0]         rsp_found_index;
   logic [olpo_pkg::POS_W-1:0]         rsp_count;

   // mirror of the list contents in list order
   logic signed [olpo_pkg::VAL_W-1:0]  list_mem [0:LIST_CAP-1];
   int                                 list_len = 0;
   bit                                 list_growing = 1'b1;
   list_reply_type                     pending_replies [$];

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int rsp_hold_left = 0;
   int mismatch_count = 0;
   int requests_sent  = 0;
   int results_checked = 0;
   int full_hits = 0;
   int status_tally [0:7] = '{default: 0};

   ordered_list_position_ops_core #(
      .CAPACITY (LIST_CAP)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count)
   );

   // clock generation
   always #4 clock = ~clock;

   // mismatch reporting, one line per mismatch
   task automatic note_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // list mirror: insert before entry idx
   function automatic olpo_pkg::status_type list_insert(
      input int idx, input logic signed [olpo_pkg::VAL_W-1:0] v);
      if (list_len >= LIST_CAP) return olpo_pkg::ST_FULL;
      if (idx > list_len) return olpo_pkg::ST_RANGE;
      for (int i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
      list_mem[idx] = v;
      list_len++;
      if (list_len == LIST_CAP) full_hits++;
      return olpo_pkg::ST_OK;
   endfunction

   // list mirror: remove entry idx
   function automatic olpo_pkg::status_type list_remove(input int idx);
      if (list_len == 0) return olpo_pkg::ST_EMPTY;
      if (idx >= list_len) return olpo_pkg::ST_RANGE;
      for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
      list_len--;
      return olpo_pkg::ST_OK;
   endfunction

   // work out the answer to one accepted request and queue it
   task automatic predict_reply(input olpo_pkg::req_code_type kind,
                                input logic signed [olpo_pkg::VAL_W-1:0] v,
                                input logic [olpo_pkg::POS_W-1:0] pos);
      list_reply_type r;
      r.status = olpo_pkg::ST_OK;
      r.found  = '0;
      case (kind)
         olpo_pkg::REQ_INS_FRONT: r.status = list_insert(0, v);
         olpo_pkg::REQ_INS_END:   r.status = list_insert(list_len, v);
         olpo_pkg::REQ_INS_POS: begin
            if (list_len >= LIST_CAP) r.status = olpo_pkg::ST_FULL;
            else if (pos == 0) r.status = olpo_pkg::ST_RANGE;
            else r.status = list_insert(int'(pos) - 1, v);
         end
         olpo_pkg::REQ_DEL_FRONT: r.status = list_remove(0);
         olpo_pkg::REQ_DEL_END: begin
            r.status = (list_len == 0) ? olpo_pkg::ST_EMPTY : list_remove(list_len - 1);
         end
         olpo_pkg::REQ_DEL_POS: begin
            if (list_len == 0) r.status = olpo_pkg::ST_EMPTY;
            else if (pos == 0) r.status = olpo_pkg::ST_RANGE;
            else r.status = list_remove(int'(pos) - 1);
         end
         olpo_pkg::REQ_SEARCH: begin
            // first match wins
            r.status = olpo_pkg::ST_NOTFOUND;
            for (int i = 0; i < list_len; i++) begin
               if (list_mem[i] == v) begin
                  r.status = olpo_pkg::ST_OK;
                  r.found  = olpo_pkg::POS_W'(i + 1);
                  break;
               end
            end
         end
         default: ;
      endcase
      r.count = olpo_pkg::POS_W'(list_len);
      status_tally[r.status]++;
      pending_replies.push_back(r);
   endtask

   // offer one request beat, with random gaps ahead of it
   task automatic send_request(input olpo_pkg::req_code_type kind,
                               input logic signed [olpo_pkg::VAL_W-1:0] v,
                               input logic [olpo_pkg::POS_W-1:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_value    <= v;
      req_position <= pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_reply(kind, v, pos);
      requests_sent++;
   endtask

   // values biased towards duplicates, extremes and held entries
   function automatic logic signed [olpo_pkg::VAL_W-1:0] pick_value();
      logic signed [olpo_pkg::VAL_W-1:0] v;
      case ($urandom_range(3))
         0: v = $urandom;
         1: v = $signed($urandom_range(7)) - 4;
         2: begin
            case ($urandom_range(3))
               0: v = {1'b1, {(olpo_pkg::VAL_W-1){1'b0}}};
               1: v = {1'b0, {(olpo_pkg::VAL_W-1){1'b1}}};
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: v = (list_len > 0) ? list_mem[$urandom_range(list_len - 1)] : $urandom;
      endcase
      return v;
   endfunction

   // random request; the list drifts towards full, then towards empty
   task automatic make_random_request(output olpo_pkg::req_code_type kind,
                                      output logic signed [olpo_pkg::VAL_W-1:0] v,
                                      output logic [olpo_pkg::POS_W-1:0] pos);
      int  pick;
      bit  is_delete;
      pick      = $urandom_range(99);
      is_delete = 1'b0;
      if (pick < 10) begin
         kind = olpo_pkg::req_code_type'($urandom_range(7));
      end else if (pick < 25) begin
         kind = olpo_pkg::REQ_SEARCH;
      end else if (pick < (list_growing ? 95 : 30)) begin
         kind = olpo_pkg::req_code_type'($urandom_range(2));
      end else begin
         kind      = olpo_pkg::req_code_type'(3 + $urandom_range(2));
         is_delete = 1'b1;
      end
      if (is_delete) begin
         pos = (list_len == 0) ? 7'd1 : olpo_pkg::POS_W'($urandom_range(1, list_len));
      end else begin
         pos = olpo_pkg::POS_W'($urandom_range(1, list_len + 1));
      end
      if ($urandom_range(9) == 0) pos = olpo_pkg::POS_W'($urandom_range(127));
      v = pick_value();
      if (kind == olpo_pkg::REQ_SEARCH && list_len > 0 && $urandom_range(1) == 1) begin
         v = list_mem[$urandom_range(list_len - 1)];
      end
      // change direction now and then at the ends of the sweep
      if (list_growing && list_len == LIST_CAP && $urandom_range(3) == 0) list_growing = 1'b0;
      else if (!list_growing && list_len == 0 && $urandom_range(3) == 0) list_growing = 1'b1;
   endtask

   // empty list, single element and position boundaries
   task automatic test_corner_cases;
      send_request(olpo_pkg::REQ_DEL_FRONT, 32'sd5, 7'd1);
      send_request(olpo_pkg::REQ_DEL_END,   32'sd5, 7'd1);
      send_request(olpo_pkg::REQ_DEL_POS,   32'sd5, 7'd0);
      send_request(olpo_pkg::REQ_DEL_POS,   32'sd5, 7'd5);
      send_request(olpo_pkg::REQ_SEARCH,    32'sd0, 7'd1);
      send_request(olpo_pkg::REQ_INS_END,   32'sd7, 7'd1);
      send_request(olpo_pkg::REQ_SEARCH,    32'sd7, 7'd1);
      send_request(olpo_pkg::REQ_DEL_POS,   32'sd0, 7'd1);
      send_request(olpo_pkg::REQ_INS_POS,   32'sd1, 7'd0);
      send_request(olpo_pkg::REQ_INS_POS,   32'sd1, 7'd2);
      send_request(olpo_pkg::REQ_INS_POS,   {1'b0, {(olpo_pkg::VAL_W-1){1'b1}}}, 7'd1);
      send_request(olpo_pkg::REQ_INS_FRONT, {1'b1, {(olpo_pkg::VAL_W-1){1'b0}}}, 7'd127);
      send_request(olpo_pkg::REQ_INS_END,   -32'sd1, 7'd0);
      send_request(olpo_pkg::REQ_INS_POS,   32'sd0, 7'd4);
      send_request(olpo_pkg::REQ_INS_POS,   32'sh5555_5555, 7'd2);
      send_request(olpo_pkg::REQ_SEARCH,    -32'sd1, 7'd0);
      send_request(olpo_pkg::REQ_SEARCH,    {1'b1, {(olpo_pkg::VAL_W-1){1'b0}}}, 7'd127);
      send_request(olpo_pkg::REQ_SEARCH,    32'sh1234_5678, 7'd3);
      send_request(olpo_pkg::REQ_DEL_POS,   32'sd0, 7'd0);
      send_request(olpo_pkg::REQ_DEL_POS,   32'sd0, 7'd6);
      send_request(olpo_pkg::REQ_DEL_POS,   32'sd0, 7'd127);
      send_request(olpo_pkg::REQ_NONE,      $urandom, 7'd127);
      send_request(olpo_pkg::REQ_DEL_POS,   32'sd0, 7'd5);
      send_request(olpo_pkg::REQ_DEL_END,   32'sd0, 7'd0);
      send_request(olpo_pkg::REQ_DEL_FRONT, 32'sd0, 7'd0);
   endtask

   // fill to capacity, then hit the full-list and long-walk cases
   task automatic test_full_list;
      logic signed [olpo_pkg::VAL_W-1:0] last_val;
      int fill;
      fill = LIST_CAP - list_len;
      last_val = '0;
      repeat (fill) begin
         last_val = $urandom;
         send_request(olpo_pkg::REQ_INS_END, last_val, 7'($urandom_range(127)));
      end
      send_request(olpo_pkg::REQ_INS_FRONT, $urandom, 7'd1);
      send_request(olpo_pkg::REQ_INS_END,   $urandom, 7'd1);
      send_request(olpo_pkg::REQ_INS_POS,   $urandom, 7'd0);
      send_request(olpo_pkg::REQ_INS_POS,   $urandom, 7'd65);
      send_request(olpo_pkg::REQ_SEARCH,    last_val, 7'd0);
      send_request(olpo_pkg::REQ_DEL_POS,   $urandom, 7'(LIST_CAP));
      send_request(olpo_pkg::REQ_DEL_POS,   $urandom, 7'(LIST_CAP));
      send_request(olpo_pkg::REQ_INS_POS,   $urandom, 7'(LIST_CAP));
      send_request(olpo_pkg::REQ_DEL_FRONT, $urandom, 7'd0);
   endtask

   // random traffic at the given idling rates
   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
      olpo_pkg::req_code_type            kind;
      logic signed [olpo_pkg::VAL_W-1:0] v;
      logic [olpo_pkg::POS_W-1:0]        pos;
      send_idle_pct = send_pct;
      rsp_idle_pct  = recv_pct;
      repeat (n_items) begin
         make_random_request(kind, v, pos);
         send_request(kind, v, pos);
      end
   endtask

   // result side held off while requests keep coming, so the input stalls
   task automatic test_response_stall;
      olpo_pkg::req_code_type            kind;
      logic signed [olpo_pkg::VAL_W-1:0] v;
      logic [olpo_pkg::POS_W-1:0]        pos;
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      rsp_hold_left = 400;
      repeat (12) begin
         make_random_request(kind, v, pos);
         send_request(kind, v, pos);
      end
   endtask

   // receiver: random back-pressure plus an optional long hold
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // result checking against the oldest expectation
   always @(posedge clock) begin : check_results
      list_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            note_mismatch($sformatf("result beat with nothing expected (status %0d count %0d)",
                                    rsp_status, rsp_count));
         end else begin
            want = pending_replies.pop_front();
            results_checked++;
            if (rsp_status !== want.status)
               note_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_found_index !== want.found)
               note_mismatch($sformatf("found_index %0d, expected %0d", rsp_found_index,
                                       want.found));
            if (rsp_count !== want.count)
               note_mismatch($sformatf("count %0d, expected %0d", rsp_count, want.count));
         end
      end
   end

   // watchdog on cycles without any beat
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // main sequence
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_type     = olpo_pkg::REQ_NONE;
      req_value    = '0;
      req_position = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_cases();
      test_full_list();
      test_random_traffic(30, 80, 165);
      test_random_traffic(80, 30, 165);
      test_random_traffic(0, 0, 165);
      test_response_stall();

      // drain
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d requests, %0d results checked; ok %0d, empty %0d, full %0d",
               requests_sent, results_checked, status_tally[olpo_pkg::ST_OK],
               status_tally[olpo_pkg::ST_EMPTY], status_tally[olpo_pkg::ST_FULL]);
      $display("range %0d, miss %0d; list reached capacity %0d times; %0d mismatches",
               status_tally[olpo_pkg::ST_RANGE], status_tally[olpo_pkg::ST_NOTFOUND],
               full_hits, mismatch_count);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
